### hdl/cfc_pkg.sv
// package for the clipped framebuffer compositor: action and register codes,
// field widths, reset values and the blend control struct; no dependencies
`default_nettype none

package cfc_pkg;

   localparam int unsigned PIXEL_W      = 32;
   localparam int unsigned CHAN_W       = 8;
   localparam int unsigned COVERAGE_W   = 8;
   localparam int unsigned READ_COL_W   = 10;
   localparam int unsigned READ_ROW_W   = 5;
   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam int unsigned BUF_WIDTH_W  = 11;
   localparam int unsigned BUF_HEIGHT_W = 6;
   localparam int unsigned LEFT_W       = 12;
   localparam int unsigned TOP_W        = 9;
   localparam int unsigned RWIDTH_W     = 11;
   localparam int unsigned RHEIGHT_W    = 8;

   // effective buffer size and signed coordinate widths
   localparam int unsigned BW_W = 13;
   localparam int unsigned BH_W = 9;
   localparam int unsigned XW   = 14;
   localparam int unsigned YW   = 10;

   localparam logic [BUF_WIDTH_W-1:0]  RST_BUFFER_WIDTH  = 11'd1024;
   localparam logic [BUF_HEIGHT_W-1:0] RST_BUFFER_HEIGHT = 6'd32;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   typedef enum logic [1:0] {
      ACT_COVERAGE = 2'd0,
      ACT_SOURCE   = 2'd1,
      ACT_FILL     = 2'd2,
      ACT_READ     = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BUFFER_WIDTH  = 3'd0,
      CSR_BUFFER_HEIGHT = 3'd1,
      CSR_RECT_LEFT     = 3'd2,
      CSR_RECT_TOP      = 3'd3,
      CSR_RECT_WIDTH    = 3'd4,
      CSR_RECT_HEIGHT   = 3'd5,
      CSR_DRAW_COLOR    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] weight;
      logic              source_mode;
      logic              copy;
   } blend_ctl_type;

endpackage

`default_nettype wire

### hdl/cfc_req_if.sv
// request channel of the compositor: valid/ready plus one input beat
// depends on cfc_pkg for field widths
`default_nettype none

interface cfc_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [cfc_pkg::COVERAGE_W-1:0]      coverage;
   logic [cfc_pkg::PIXEL_W-1:0]         source_pixel;
   logic                                last_of_image;
   logic [cfc_pkg::READ_COL_W-1:0]      read_column;
   logic [cfc_pkg::READ_ROW_W-1:0]      read_row;

   modport source (
      output valid, action, coverage, source_pixel, last_of_image, read_column, read_row,
      input  ready
   );
   modport sink (
      input  valid, action, coverage, source_pixel, last_of_image, read_column, read_row,
      output ready
   );
endinterface

`default_nettype wire

### hdl/cfc_rsp_if.sv
// response channel of the compositor: valid/ready plus one result beat
// depends on cfc_pkg for field widths
`default_nettype none

interface cfc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cfc_pkg::PIXEL_W-1:0]      read_data;
   logic                             in_bounds;
   logic [cfc_pkg::COUNT_W-1:0]      pixels_written;

   modport source (
      output valid, read_data, in_bounds, pixels_written,
      input  ready
   );
   modport sink (
      input  valid, read_data, in_bounds, pixels_written,
      output ready
   );
endinterface

`default_nettype wire

### hdl/cfc_frame_mem.sv
// framebuffer memory: one write port, one read port with registered data
// depends on cfc_pkg for the pixel width
`default_nettype none

module cfc_frame_mem #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic [cfc_pkg::PIXEL_W-1:0]      rd_data,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [cfc_pkg::PIXEL_W-1:0] wr_data
);

   logic [cfc_pkg::PIXEL_W-1:0] mem [DEPTH];
   logic [cfc_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/cfc_blend.sv
// per-channel lerp of a stored pixel toward a source color, floor rounding
// depends on cfc_pkg for the blend control struct and widths
`default_nettype none

module cfc_blend (
   input  wire logic [cfc_pkg::PIXEL_W-1:0] dst_pixel,
   input  wire logic [cfc_pkg::PIXEL_W-1:0] src_pixel,
   input  wire cfc_pkg::blend_ctl_type      ctl,
   output logic [cfc_pkg::PIXEL_W-1:0]      blend_pixel
);

   // floor(d + (s - d) * w / 256), kept modulo 256
   function automatic logic [cfc_pkg::CHAN_W-1:0] lerp8(
      input logic [cfc_pkg::CHAN_W-1:0] d,
      input logic [cfc_pkg::CHAN_W-1:0] s,
      input logic [cfc_pkg::CHAN_W-1:0] w
   );
      logic signed [cfc_pkg::CHAN_W:0]     diff;
      logic signed [2*cfc_pkg::CHAN_W+1:0] prod;
      diff = $signed({1'b0, s}) - $signed({1'b0, d});
      prod = (2*cfc_pkg::CHAN_W+2)'(diff) * (2*cfc_pkg::CHAN_W+2)'($signed({1'b0, w}));
      return d + prod[cfc_pkg::CHAN_W +: cfc_pkg::CHAN_W];
   endfunction

   logic [cfc_pkg::CHAN_W-1:0] out_a, out_r, out_g, out_b;

   always_comb begin
      out_a = lerp8(dst_pixel[31:24], src_pixel[31:24], ctl.weight);
      out_r = lerp8(dst_pixel[23:16], src_pixel[23:16], ctl.weight);
      out_g = lerp8(dst_pixel[15:8],  src_pixel[15:8],  ctl.weight);
      out_b = lerp8(dst_pixel[7:0],   src_pixel[7:0],   ctl.weight);
      if (ctl.source_mode) begin
         if (ctl.copy) begin
            blend_pixel = {cfc_pkg::CHAN_MAX, src_pixel[23:0]};
         end else begin
            blend_pixel = {cfc_pkg::CHAN_MAX, out_r, out_g, out_b};
         end
      end else begin
         blend_pixel = {out_a, out_r, out_g, out_b};
      end
   end

endmodule

`default_nettype wire

### hdl/clipped_framebuffer_compositor_top.sv
// Blend, raster and read items: the frame memory read is registered at accept, then the lerp
// and write back go with the registered result; a new item waits until this one is done.
// Fill items: each clipped pixel is written in ST_FILL, then ST_FINISH registers the result;
// one memory write per cycle. One item is in work at a time; the next is taken while a
// result waits, and a stalled result holds the item in its last state.
// Synchronous active-high reset clears control, raster position and config;
// the frame memory is not cleared and has no clearing pass.
`default_nettype none

module clipped_framebuffer_compositor_top #(
   parameter int MAX_BUFFER_WIDTH  = 1024,
   parameter int MAX_BUFFER_HEIGHT = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   cfc_req_if.sink                                req_bus,
   cfc_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [cfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W = $clog2(MAX_BUFFER_WIDTH);
   localparam int ROW_W = (MAX_BUFFER_HEIGHT > 1) ? $clog2(MAX_BUFFER_HEIGHT) : 1;
   localparam int DEPTH = MAX_BUFFER_WIDTH * MAX_BUFFER_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   localparam int BW_W = cfc_pkg::BW_W;
   localparam int BH_W = cfc_pkg::BH_W;
   localparam int XW   = cfc_pkg::XW;
   localparam int YW   = cfc_pkg::YW;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ACCESS = 4'b0010,
      ST_FILL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [cfc_pkg::BUF_WIDTH_W-1:0]  buffer_width;
      logic [cfc_pkg::BUF_HEIGHT_W-1:0] buffer_height;
      logic [cfc_pkg::LEFT_W-1:0]       rect_left;
      logic [cfc_pkg::TOP_W-1:0]        rect_top;
      logic [cfc_pkg::RWIDTH_W-1:0]     rect_width;
      logic [cfc_pkg::RHEIGHT_W-1:0]    rect_height;
      logic [cfc_pkg::PIXEL_W-1:0]      draw_color;
   } csr_type;

   typedef struct packed {
      logic                        is_read;
      logic                        inb;
      logic                        do_write;
      logic [AW-1:0]               addr;
      logic [cfc_pkg::PIXEL_W-1:0] src;
      cfc_pkg::blend_ctl_type      ctl;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] x0;
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
      logic [BW_W-1:0]  w;
      logic [BH_W-1:0]  h;
   } fill_type;

   typedef struct packed {
      logic [cfc_pkg::PIXEL_W-1:0] read_data;
      logic                        in_bounds;
      logic [cfc_pkg::COUNT_W-1:0] pixels_written;
   } rsp_type;

   state_type                        state_ff, state_in;
   csr_type                          csr_ff, csr_in;
   item_type                         item_ff, item_in;
   fill_type                         fill_ff, fill_in;
   rsp_type                          rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cfc_pkg::RWIDTH_W-1:0]     raster_col_ff, raster_col_in;
   logic [cfc_pkg::RHEIGHT_W-1:0]    raster_row_ff, raster_row_in;

   cfc_pkg::action_type              action;
   logic                             accept;
   logic                             out_free;
   logic [BW_W-1:0]                  bw_eff;
   logic [BH_W-1:0]                  bh_eff;
   logic signed [XW-1:0]             left_x, bw_x, ras_x, fx0, fx1, fx1_raw;
   logic signed [YW-1:0]             top_y, bh_y, ras_y, fy0, fy1, fy1_raw;
   logic                             ras_inb, rd_inb, fill_nonempty;
   logic [cfc_pkg::RWIDTH_W:0]       col_next;
   logic [2*cfc_pkg::CHAN_W-1:0]     cov_prod;
   logic [cfc_pkg::CHAN_W-1:0]       cov_weight, src_alpha;
   logic [COL_W-1:0]                 acc_col;
   logic [ROW_W-1:0]                 acc_row;
   logic [AW-1:0]                    acc_addr, fill_addr;
   logic [BW_W+BH_W-1:0]             fill_count;
   logic                             fill_done;

   logic                             mem_rd_en, mem_wr_en;
   logic [AW-1:0]                    mem_wr_addr;
   logic [cfc_pkg::PIXEL_W-1:0]      mem_rd_data, mem_wr_data, blend_pixel;

   assign action   = cfc_pkg::action_type'(req_bus.action);
   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_data      = rsp_ff.read_data;
   assign rsp_bus.in_bounds      = rsp_ff.in_bounds;
   assign rsp_bus.pixels_written = rsp_ff.pixels_written;

   // geometry
   always_comb begin
      bw_eff = (BW_W'(csr_ff.buffer_width) > BW_W'(MAX_BUFFER_WIDTH))
             ? BW_W'(MAX_BUFFER_WIDTH) : BW_W'(csr_ff.buffer_width);
      bh_eff = (BH_W'(csr_ff.buffer_height) > BH_W'(MAX_BUFFER_HEIGHT))
             ? BH_W'(MAX_BUFFER_HEIGHT) : BH_W'(csr_ff.buffer_height);
      left_x = XW'($signed(csr_ff.rect_left));
      top_y  = YW'($signed(csr_ff.rect_top));
      bw_x   = $signed(XW'(bw_eff));
      bh_y   = $signed(YW'(bh_eff));

      ras_x   = left_x + $signed(XW'(raster_col_ff));
      ras_y   = top_y + $signed(YW'(raster_row_ff));
      ras_inb = (raster_col_ff < csr_ff.rect_width) && (raster_row_ff < csr_ff.rect_height)
             && !ras_x[XW-1] && (ras_x < bw_x) && !ras_y[YW-1] && (ras_y < bh_y);
      rd_inb  = (BW_W'(req_bus.read_column) < bw_eff) && (BH_W'(req_bus.read_row) < bh_eff);

      fx0     = left_x[XW-1] ? '0 : left_x;
      fy0     = top_y[YW-1] ? '0 : top_y;
      fx1_raw = left_x + $signed(XW'(csr_ff.rect_width));
      fy1_raw = top_y + $signed(YW'(csr_ff.rect_height));
      fx1     = (fx1_raw > bw_x) ? bw_x : fx1_raw;
      fy1     = (fy1_raw > bh_y) ? bh_y : fy1_raw;
      fill_nonempty = (fx1 > fx0) && (fy1 > fy0);

      col_next   = {1'b0, raster_col_ff} + (cfc_pkg::RWIDTH_W+1)'(1);
      cov_prod   = (2*cfc_pkg::CHAN_W)'(req_bus.coverage)
                 * (2*cfc_pkg::CHAN_W)'(csr_ff.draw_color[31:24]);
      cov_weight = cov_prod[2*cfc_pkg::CHAN_W-1:cfc_pkg::CHAN_W];
      src_alpha  = req_bus.source_pixel[31:24];

      acc_col  = (action == cfc_pkg::ACT_READ) ? COL_W'(req_bus.read_column) : COL_W'(ras_x);
      acc_row  = (action == cfc_pkg::ACT_READ) ? ROW_W'(req_bus.read_row) : ROW_W'(ras_y);
      acc_addr = AW'(acc_row * MAX_BUFFER_WIDTH) + AW'(acc_col);

      fill_addr  = AW'(fill_ff.row * MAX_BUFFER_WIDTH) + AW'(fill_ff.col);
      fill_count = (BW_W+BH_W)'(fill_ff.w) * (BW_W+BH_W)'(fill_ff.h);
      fill_done  = (fill_ff.col == fill_ff.last_col) && (fill_ff.row == fill_ff.last_row);
   end

   // config writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (cfc_pkg::csr_index_type'(csr_index))
            cfc_pkg::CSR_BUFFER_WIDTH:  csr_in.buffer_width  = csr_wdata[cfc_pkg::BUF_WIDTH_W-1:0];
            cfc_pkg::CSR_BUFFER_HEIGHT: csr_in.buffer_height = csr_wdata[cfc_pkg::BUF_HEIGHT_W-1:0];
            cfc_pkg::CSR_RECT_LEFT:     csr_in.rect_left     = csr_wdata[cfc_pkg::LEFT_W-1:0];
            cfc_pkg::CSR_RECT_TOP:      csr_in.rect_top      = csr_wdata[cfc_pkg::TOP_W-1:0];
            cfc_pkg::CSR_RECT_WIDTH:    csr_in.rect_width    = csr_wdata[cfc_pkg::RWIDTH_W-1:0];
            cfc_pkg::CSR_RECT_HEIGHT:   csr_in.rect_height   = csr_wdata[cfc_pkg::RHEIGHT_W-1:0];
            cfc_pkg::CSR_DRAW_COLOR:    csr_in.draw_color    = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      fill_in       = fill_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      raster_col_in = raster_col_ff;
      raster_row_in = raster_row_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in.is_read  = (action == cfc_pkg::ACT_READ);
               item_in.inb      = 1'b0;
               item_in.do_write = 1'b0;
               item_in.addr     = acc_addr;
               item_in.src      = csr_ff.draw_color;
               item_in.ctl      = '{weight: cov_weight, source_mode: 1'b0, copy: 1'b0};
               state_in         = ST_ACCESS;
               if (action == cfc_pkg::ACT_COVERAGE || action == cfc_pkg::ACT_SOURCE) begin
                  if (col_next >= (cfc_pkg::RWIDTH_W+1)'(csr_ff.rect_width)) begin
                     raster_col_in = '0;
                     raster_row_in = raster_row_ff + cfc_pkg::RHEIGHT_W'(1);
                  end else begin
                     raster_col_in = col_next[cfc_pkg::RWIDTH_W-1:0];
                  end
                  if (req_bus.last_of_image) begin
                     raster_col_in = '0;
                     raster_row_in = '0;
                  end
               end
               case (action)
                  cfc_pkg::ACT_READ: begin
                     item_in.inb = rd_inb;
                  end
                  cfc_pkg::ACT_FILL: begin
                     item_in.inb      = fill_nonempty;
                     fill_in.col      = COL_W'(fx0);
                     fill_in.x0       = COL_W'(fx0);
                     fill_in.row      = ROW_W'(fy0);
                     fill_in.last_col = COL_W'(fx1 - XW'(1));
                     fill_in.last_row = ROW_W'(fy1 - YW'(1));
                     fill_in.w        = BW_W'(fx1 - fx0);
                     fill_in.h        = BH_W'(fy1 - fy0);
                     state_in         = fill_nonempty ? ST_FILL : ST_FINISH;
                  end
                  cfc_pkg::ACT_COVERAGE: begin
                     item_in.inb      = ras_inb;
                     item_in.do_write = ras_inb && (cov_weight != '0);
                  end
                  cfc_pkg::ACT_SOURCE: begin
                     item_in.inb      = ras_inb;
                     item_in.do_write = ras_inb && (src_alpha != '0);
                     item_in.src      = req_bus.source_pixel;
                     item_in.ctl      = '{weight: src_alpha, source_mode: 1'b1,
                                          copy: (src_alpha == cfc_pkg::CHAN_MAX)};
                  end
                  default: ;
               endcase
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.read_data      = (item_ff.is_read && item_ff.inb) ? mem_rd_data : '0;
               rsp_in.in_bounds      = item_ff.inb;
               rsp_in.pixels_written = cfc_pkg::COUNT_W'(item_ff.do_write);
               state_in              = ST_IDLE;
            end
         end
         ST_FILL: begin
            if (fill_ff.col == fill_ff.last_col) begin
               fill_in.col = fill_ff.x0;
               if (fill_done) begin
                  state_in = ST_FINISH;
               end else begin
                  fill_in.row = fill_ff.row + ROW_W'(1);
               end
            end else begin
               fill_in.col = fill_ff.col + COL_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.read_data      = '0;
               rsp_in.in_bounds      = item_ff.inb;
               rsp_in.pixels_written = item_ff.inb ? fill_count[cfc_pkg::COUNT_W-1:0] : '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_rd_en   = accept && (action != cfc_pkg::ACT_FILL);
   assign mem_wr_en   = (state_ff == ST_FILL)
                     || ((state_ff == ST_ACCESS) && out_free && item_ff.do_write);
   assign mem_wr_addr = (state_ff == ST_FILL) ? fill_addr : item_ff.addr;
   assign mem_wr_data = (state_ff == ST_FILL) ? csr_ff.draw_color : blend_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         raster_col_ff <= '0;
         raster_row_ff <= '0;
         csr_ff        <= '{buffer_width: cfc_pkg::RST_BUFFER_WIDTH,
                            buffer_height: cfc_pkg::RST_BUFFER_HEIGHT,
                            rect_left: '0, rect_top: '0, rect_width: '0,
                            rect_height: '0, draw_color: '0};
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         raster_col_ff <= raster_col_in;
         raster_row_ff <= raster_row_in;
         csr_ff        <= csr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      fill_ff <= fill_in;
      rsp_ff  <= rsp_in;
   end

   cfc_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_frame_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (acc_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   cfc_blend u_blend (
      .dst_pixel   (mem_rd_data),
      .src_pixel   (item_ff.src),
      .ctl         (item_ff.ctl),
      .blend_pixel (blend_pixel)
   );

`ifndef SYNTHESIS
   a_fill_clipped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (BW_W'(fill_ff.col) < bw_eff) && (BH_W'(fill_ff.row) < bh_eff))
      else $error("fill walks outside the buffer");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_of_image
      && (action == cfc_pkg::ACT_COVERAGE || action == cfc_pkg::ACT_SOURCE)
      |=> (raster_col_ff == '0) && (raster_row_ff == '0))
      else $error("raster position not rewound after last beat");

   a_write_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCESS) && item_ff.do_write |-> item_ff.inb && !item_ff.is_read)
      else $error("blend write for a pixel outside the target");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ACCESS || $past(state_ff) == ST_FINISH))
      else $error("response beat without finished item");
`endif

endmodule

`default_nettype wire

### verif/cfc_frame_checker.sv
// frame checker for the clipped framebuffer compositor: keeps a shadow frame store,
// predicts every response beat from the request and csr traffic and compares it
// depends on cfc_pkg and the cfc_req_if / cfc_rsp_if interfaces
module cfc_frame_checker
   import cfc_pkg::*;
#(
   parameter int MAX_W = 1024,
   parameter int MAX_H = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cfc_req_if                          req_mon,
   cfc_rsp_if                          rsp_mon,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          outstanding
);

   typedef struct packed {
      logic [PIXEL_W-1:0] read_data;
      logic               in_bounds;
      logic [COUNT_W-1:0] pixels_written;
   } pixel_result_t;

   pixel_result_t expected_pixels[$];

   logic [PIXEL_W-1:0]      frame_copy [MAX_W*MAX_H];
   logic [BUF_WIDTH_W-1:0]  cfg_buf_w;
   logic [BUF_HEIGHT_W-1:0] cfg_buf_h;
   logic [LEFT_W-1:0]       cfg_left;
   logic [TOP_W-1:0]        cfg_top;
   logic [RWIDTH_W-1:0]     cfg_rwidth;
   logic [RHEIGHT_W-1:0]    cfg_rheight;
   logic [PIXEL_W-1:0]      cfg_color;
   logic [RWIDTH_W-1:0]     raster_col;
   logic [RHEIGHT_W-1:0]    raster_row;

   initial begin
      for (int i = 0; i < MAX_W*MAX_H; i++) frame_copy[i] = '0;
   end

   // signed floor of d + (s - d) * w / 256
   function automatic logic [CHAN_W-1:0] lerp_chan(input logic [CHAN_W-1:0] d,
                                                   input logic [CHAN_W-1:0] s,
                                                   input logic [CHAN_W-1:0] w);
      int prod;
      prod = (int'(s) - int'(d)) * int'(w);
      return CHAN_W'(int'(d) + (prod >>> 8));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 50)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_BUFFER_WIDTH:  cfg_buf_w   = val[BUF_WIDTH_W-1:0];
         CSR_BUFFER_HEIGHT: cfg_buf_h   = val[BUF_HEIGHT_W-1:0];
         CSR_RECT_LEFT:     cfg_left    = val[LEFT_W-1:0];
         CSR_RECT_TOP:      cfg_top     = val[TOP_W-1:0];
         CSR_RECT_WIDTH:    cfg_rwidth  = val[RWIDTH_W-1:0];
         CSR_RECT_HEIGHT:   cfg_rheight = val[RHEIGHT_W-1:0];
         CSR_DRAW_COLOR:    cfg_color   = val;
         default: ;
      endcase
   endtask

   task automatic predict_beat(input logic [1:0] act, input logic [COVERAGE_W-1:0] cov,
                               input logic [PIXEL_W-1:0] src, input logic last,
                               input logic [READ_COL_W-1:0] rcol,
                               input logic [READ_ROW_W-1:0] rrow);
      int bw, bh, left, top, x0, y0, x1, y1, x, y, idx, next_col;
      pixel_result_t res;
      logic [PIXEL_W-1:0] d;
      logic [CHAN_W-1:0] ca, a, sa;
      bw   = (int'(cfg_buf_w) > MAX_W) ? MAX_W : int'(cfg_buf_w);
      bh   = (int'(cfg_buf_h) > MAX_H) ? MAX_H : int'(cfg_buf_h);
      left = int'($signed(cfg_left));
      top  = int'($signed(cfg_top));
      res  = '0;
      case (action_type'(act))
         ACT_READ: begin
            if (int'(rcol) < bw && int'(rrow) < bh) begin
               res.in_bounds = 1'b1;
               res.read_data = frame_copy[int'(rrow)*MAX_W + int'(rcol)];
            end
         end
         ACT_FILL: begin
            x0 = (left < 0) ? 0 : left;
            y0 = (top < 0) ? 0 : top;
            x1 = left + int'(cfg_rwidth);
            y1 = top + int'(cfg_rheight);
            if (x1 > bw) x1 = bw;
            if (y1 > bh) y1 = bh;
            if (x1 > x0 && y1 > y0) begin
               res.in_bounds = 1'b1;
               for (int r = y0; r < y1; r++)
                  for (int c = x0; c < x1; c++) frame_copy[r*MAX_W + c] = cfg_color;
               res.pixels_written = COUNT_W'((x1 - x0) * (y1 - y0));
            end
         end
         default: begin
            x = left + int'(raster_col);
            y = top + int'(raster_row);
            if (raster_col < cfg_rwidth && raster_row < cfg_rheight &&
                x >= 0 && x < bw && y >= 0 && y < bh) begin
               idx = y*MAX_W + x;
               d   = frame_copy[idx];
               res.in_bounds = 1'b1;
               if (action_type'(act) == ACT_COVERAGE) begin
                  ca = cfg_color[31:24];
                  a  = CHAN_W'((16'(cov) * 16'(ca)) >> 8);
                  if (a != '0) begin
                     frame_copy[idx] = {lerp_chan(d[31:24], ca, a),
                                        lerp_chan(d[23:16], cfg_color[23:16], a),
                                        lerp_chan(d[15:8], cfg_color[15:8], a),
                                        lerp_chan(d[7:0], cfg_color[7:0], a)};
                     res.pixels_written = 1;
                  end
               end else begin
                  sa = src[31:24];
                  if (sa == CHAN_MAX) begin
                     frame_copy[idx] = {CHAN_MAX, src[23:0]};
                     res.pixels_written = 1;
                  end else if (sa != '0) begin
                     frame_copy[idx] = {CHAN_MAX,
                                        lerp_chan(d[23:16], src[23:16], sa),
                                        lerp_chan(d[15:8], src[15:8], sa),
                                        lerp_chan(d[7:0], src[7:0], sa)};
                     res.pixels_written = 1;
                  end
               end
            end
            next_col = int'(raster_col) + 1;
            if (next_col >= int'(cfg_rwidth)) begin
               raster_col = '0;
               raster_row = raster_row + 1'b1;
            end else begin
               raster_col = RWIDTH_W'(next_col);
            end
            if (last) begin
               raster_col = '0;
               raster_row = '0;
            end
         end
      endcase
      expected_pixels.push_back(res);
   endtask

   task automatic check_beat();
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("beat with nothing expected, read_data", rsp_mon.read_data, '0);
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_mon.read_data !== want.read_data)
         report_mismatch("read_data", rsp_mon.read_data, want.read_data);
      if (rsp_mon.in_bounds !== want.in_bounds)
         report_mismatch("in_bounds", 32'(rsp_mon.in_bounds), 32'(want.in_bounds));
      if (rsp_mon.pixels_written !== want.pixels_written)
         report_mismatch("pixels_written", 32'(rsp_mon.pixels_written),
                         32'(want.pixels_written));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         mismatches  = 0;
         cfg_buf_w   = RST_BUFFER_WIDTH;
         cfg_buf_h   = RST_BUFFER_HEIGHT;
         cfg_left    = '0;
         cfg_top     = '0;
         cfg_rwidth  = '0;
         cfg_rheight = '0;
         cfg_color   = '0;
         raster_col  = '0;
         raster_row  = '0;
         outstanding <= 0;
      end else begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
         if (req_mon.valid && req_mon.ready)
            predict_beat(req_mon.action, req_mon.coverage, req_mon.source_pixel,
                         req_mon.last_of_image, req_mon.read_column, req_mon.read_row);
         outstanding <= expected_pixels.size();
      end
   end

endmodule

### verif/tb_clipped_framebuffer_compositor_top.sv
// testbench top for the clipped framebuffer compositor: clock, reset, csr setup,
// directed and random request beats, response stalls, watchdog and verdict
// depends on cfc_pkg, the channel interfaces, the block and cfc_frame_checker
module tb_clipped_framebuffer_compositor_top;
   import cfc_pkg::*;

   localparam int MAX_W       = 1024;
   localparam int MAX_H       = 32;
   localparam int IDLE_LIMIT  = 200000;
   localparam int TOTAL_BEATS = 1080;
   localparam int QUIET_FROM  = 950;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int beats_sent = 0;
   int idle_cycles = 0;
   int ready_hold = 0;
   bit quiet = 1'b0;
   bit stalls_on = 1'b1;
   int cur_bw, cur_bh, cur_rw, cur_rh;

   cfc_req_if req_bus ();
   cfc_rsp_if rsp_bus ();

   clipped_framebuffer_compositor_top #(
      .MAX_BUFFER_WIDTH  (MAX_W),
      .MAX_BUFFER_HEIGHT (MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfc_frame_checker #(
      .MAX_W (MAX_W),
      .MAX_H (MAX_H)
   ) frame_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random response stalls: ready is held low for a burst of random length
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold    <= ready_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
         ready_hold    <= $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic send_beat(input action_type act, input logic [COVERAGE_W-1:0] cov,
                            input logic [PIXEL_W-1:0] src, input logic last,
                            input logic [READ_COL_W-1:0] col,
                            input logic [READ_ROW_W-1:0] row);
      int gap;
      if (!quiet && stalls_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.coverage      <= cov;
      req_bus.source_pixel  <= src;
      req_bus.last_of_image <= last;
      req_bus.read_column   <= col;
      req_bus.read_row      <= row;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_registers(input int bw, input int bh, input int left, input int top,
                                input int rw, input int rh, input logic [31:0] color);
      wait_drained();
      write_reg(CSR_BUFFER_WIDTH, 32'(BUF_WIDTH_W'(bw)));
      write_reg(CSR_BUFFER_HEIGHT, 32'(BUF_HEIGHT_W'(bh)));
      write_reg(CSR_RECT_LEFT, 32'(LEFT_W'(left)));
      write_reg(CSR_RECT_TOP, 32'(TOP_W'(top)));
      write_reg(CSR_RECT_WIDTH, 32'(RWIDTH_W'(rw)));
      write_reg(CSR_RECT_HEIGHT, 32'(RHEIGHT_W'(rh)));
      write_reg(CSR_DRAW_COLOR, color);
      csr_we <= 1'b0;
      cur_bw = (bw > MAX_W) ? MAX_W : bw;
      cur_bh = (bh > MAX_H) ? MAX_H : bh;
      cur_rw = rw;
      cur_rh = rh;
   endtask

   task automatic set_random_registers(input bit wide);
      int bw, bh, left, top, rw, rh, ebw, ebh;
      logic [31:0] color;
      case ($urandom_range(0, 9))
         0:       bw = 0;
         1:       bw = $urandom_range(1025, 2047);
         2:       bw = 1;
         3:       bw = MAX_W;
         default: bw = $urandom_range(2, MAX_W - 1);
      endcase
      case ($urandom_range(0, 9))
         0:       bh = 0;
         1:       bh = $urandom_range(33, 63);
         2:       bh = 1;
         default: bh = $urandom_range(2, MAX_H);
      endcase
      ebw = (bw > MAX_W) ? MAX_W : bw;
      ebh = (bh > MAX_H) ? MAX_H : bh;
      if ($urandom_range(0, 9) == 0) left = int'($urandom_range(0, 4095)) - 2048;
      else left = int'($urandom_range(0, ebw + 8)) - 8;
      if ($urandom_range(0, 9) == 0) top = int'($urandom_range(0, 511)) - 256;
      else top = int'($urandom_range(0, ebh + 4)) - 4;
      if (wide) begin
         rw = $urandom_range(0, 2047);
         rh = $urandom_range(0, 255);
      end else begin
         rw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
         rh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      end
      color = $urandom();
      case ($urandom_range(0, 5))
         0:       color[31:24] = 8'h00;
         1:       color[31:24] = 8'hFF;
         default: ;
      endcase
      set_registers(bw, bh, left, top, rw, rh, color);
   endtask

   task automatic send_fill();
      send_beat(ACT_FILL, 8'($urandom()), $urandom(), 1'($urandom()), 10'($urandom()),
                5'($urandom()));
   endtask

   task automatic send_read();
      logic [READ_COL_W-1:0] col;
      logic [READ_ROW_W-1:0] row;
      if (cur_bw > 0 && $urandom_range(0, 4) != 0) col = 10'($urandom_range(0, cur_bw - 1));
      else col = 10'($urandom());
      if (cur_bh > 0 && $urandom_range(0, 4) != 0) row = 5'($urandom_range(0, cur_bh - 1));
      else row = 5'($urandom());
      send_beat(ACT_READ, 8'($urandom()), $urandom(), 1'($urandom()), col, row);
   endtask

   // one raster image over the rectangle, cut short when the rectangle is large
   task automatic send_image();
      int count;
      action_type act;
      count = cur_rw * cur_rh;
      if (count > 48) count = 48;
      if (count == 0) count = 1;
      act = ($urandom_range(0, 1) == 0) ? ACT_COVERAGE : ACT_SOURCE;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) act = (act == ACT_SOURCE) ? ACT_COVERAGE : ACT_SOURCE;
         send_beat(act, pick_byte(), {pick_byte(), 24'($urandom())}, i == count - 1,
                   10'($urandom()), 5'($urandom()));
      end
   endtask

   initial begin
      int kind;
      bit wide;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_BUFFER_WIDTH;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_READ;
      req_bus.coverage      <= '0;
      req_bus.source_pixel  <= '0;
      req_bus.last_of_image <= 1'b0;
      req_bus.read_column   <= '0;
      req_bus.read_row      <= '0;
      cur_bw = MAX_W;
      cur_bh = MAX_H;
      cur_rw = 0;
      cur_rh = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty rectangle
      send_beat(ACT_FILL, 8'h00, 32'h0, 1'b1, 10'h0, 5'h0);
      send_beat(ACT_COVERAGE, 8'hFF, 32'hFFFFFFFF, 1'b1, 10'h3FF, 5'h1F);

      // whole buffer fill so every entry holds a known pixel
      set_registers(1024, 32, 0, 0, 1024, 32, 32'h80402010);
      send_fill();
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd0, 5'd0);
      send_beat(ACT_READ, 8'hFF, 32'hFFFFFFFF, 1'b1, 10'd1023, 5'd31);

      // oversize buffer, rectangle at the most negative corner
      set_registers(2047, 63, -2048, -256, 1024, 255, 32'hFFFFFFFF);
      send_fill();
      send_beat(ACT_COVERAGE, 8'hFF, 32'h0, 1'b1, 10'h0, 5'h0);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd1023, 5'd31);

      // small rectangle hanging over the top left edge
      set_registers(16, 4, -2, -1, 4, 3, 32'hC0FF8000);
      send_beat(ACT_COVERAGE, 8'hFF, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_COVERAGE, 8'hFF, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_COVERAGE, 8'h00, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_COVERAGE, 8'h80, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_SOURCE, 8'h00, 32'h00123456, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_SOURCE, 8'h00, 32'hFFABCDEF, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_SOURCE, 8'h00, 32'h7F00FF80, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_COVERAGE, 8'hFF, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_SOURCE, 8'h00, 32'h01FFFFFF, 1'b1, 10'h0, 5'h0);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b1, 10'd0, 5'd0);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd1, 5'd1);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd1023, 5'd0);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd0, 5'd31);
      send_beat(ACT_FILL, 8'h00, 32'h0, 1'b1, 10'h0, 5'h0);

      // empty buffer, rectangle at the most positive corner, transparent color
      set_registers(0, 0, 2047, 255, 1, 1, 32'h00FFFFFF);
      send_fill();
      send_beat(ACT_COVERAGE, 8'hFF, 32'h0, 1'b0, 10'h0, 5'h0);
      send_beat(ACT_READ, 8'h00, 32'h0, 1'b0, 10'd0, 5'd0);

      while (beats_sent < TOTAL_BEATS) begin
         wide      = ($urandom_range(0, 7) == 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         set_random_registers(wide);
         if (wide && $urandom_range(0, 1) == 0) send_fill();
         repeat ($urandom_range(2, 5)) begin
            if (beats_sent >= TOTAL_BEATS) break;
            kind = $urandom_range(0, 99);
            if (kind < 55) send_image();
            else if (kind < 70 && !wide) send_fill();
            else if (kind < 92) send_read();
            else
               send_beat(action_type'($urandom_range(0, 1)), pick_byte(), $urandom(),
                         1'($urandom_range(0, 3) == 0), 10'($urandom()), 5'($urandom()));
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
         if (beats_sent >= QUIET_FROM) quiet = 1'b1;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
